### src/cbcs_pkg.sv
// Shared types and constants for the cubic Bezier color sampler.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package cbcs_pkg;

  // Sampling and fixed-point format
  localparam int SAMPLES = 8192;
  localparam int Q_FRAC  = 16;
  localparam int ONE_Q16 = 65536;

  // Field and datapath widths
  localparam int S_W     = 14;               // sample index
  localparam int T_W     = 17;               // t in Q1.16, 0..1 inclusive
  localparam int T3_W    = T_W + 2;          // 3*t for the segment test
  localparam int COORD_W = 16;
  localparam int COEF_W  = 20;               // power-basis coefficients
  localparam int A_W     = 38;               // c3*t + c2, scale 2^16
  localparam int B_W     = 54;               // a*t + c1, scale 2^32
  localparam int N_W     = 72;               // b*t + c0 + 1/2, scale 2^48
  localparam int R_W     = N_W - 3 * Q_FRAC; // rounded value before clamp
  localparam int A_LO_W  = 19;               // split of a for a*t
  localparam int AH_W    = A_W - A_LO_W;
  localparam int AHT_W   = AH_W + T_W + 1;
  localparam int ALT_W   = A_LO_W + T_W;
  localparam int B_LO_W  = 27;               // split of b for b*t
  localparam int BH_W    = B_W - B_LO_W;
  localparam int BHT_W   = BH_W + T_W + 1;
  localparam int BLT_W   = B_LO_W + T_W;
  localparam int BLEND_W = 25;

  // Sample queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Input word kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Color segment of t
  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_MID,
    SEG_HIGH
  } seg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    coef_t  c3;
    coef_t  c2;
    coef_t  c1;
    coord_t c0;
  } axis_coef_t;

  // One sample job as queued by the front
  typedef struct packed {
    logic [T_W-1:0] t;
    axis_coef_t     cx;
    axis_coef_t     cy;
    rgb_t           ca;   // weighted by t
    rgb_t           cb;   // weighted by 1 - t
  } job_t;

  typedef struct packed {
    logic         mode;
    logic [1:0]   point_index;
    coord_t       point_x;
    coord_t       point_y;
    logic [7:0]   point_red;
    logic [7:0]   point_green;
    logic [7:0]   point_blue;
    logic [S_W-1:0] sample_index;
  } in_word_t;

  typedef struct packed {
    coord_t     pixel_x;
    coord_t     pixel_y;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } out_word_t;

endpackage

### src/cbcs_front.sv
// Front end: accepts input words, stores control points, turns samples into jobs.
// Depends on cbcs_pkg.
`timescale 1ns / 1ps

module cbcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbcs_pkg::in_word_t  in_word,
  input  logic                q_full,
  output logic                q_push,
  output cbcs_pkg::job_t      q_job
);

  cbcs_pkg::coord_t ctrl_x_r [4];
  cbcs_pkg::coord_t ctrl_y_r [4];
  cbcs_pkg::rgb_t   ctrl_c_r [4];

  logic                       accept;
  logic [cbcs_pkg::S_W-1:0]   s_clamp;
  logic [31:0]                t_wide;
  logic [cbcs_pkg::T_W-1:0]   t;
  logic [cbcs_pkg::T3_W-1:0]  t3;
  cbcs_pkg::seg_t             seg;

  // 3*v by shift and add
  function automatic cbcs_pkg::coef_t mul3(input cbcs_pkg::coef_t v);
    return (v <<< 1) + v;
  endfunction

  // Bezier basis matrix applied to four control coordinates
  function automatic cbcs_pkg::axis_coef_t calc_coef(
    input cbcs_pkg::coord_t p0,
    input cbcs_pkg::coord_t p1,
    input cbcs_pkg::coord_t p2,
    input cbcs_pkg::coord_t p3
  );
    cbcs_pkg::coef_t      e0, e1, e2, e3;
    cbcs_pkg::axis_coef_t c;
    e0   = cbcs_pkg::COEF_W'(p0);
    e1   = cbcs_pkg::COEF_W'(p1);
    e2   = cbcs_pkg::COEF_W'(p2);
    e3   = cbcs_pkg::COEF_W'(p3);
    c.c3 = (e3 - e0) + mul3(e1 - e2);
    c.c2 = mul3(e0 + e2) - mul3(e1 <<< 1);
    c.c1 = mul3(e1 - e0);
    c.c0 = p0;
    return c;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (in_word.mode == cbcs_pkg::MODE_SAMPLE);

  // Control point store, written by load words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        ctrl_x_r[i] <= '0;
        ctrl_y_r[i] <= '0;
        ctrl_c_r[i] <= '0;
      end
    end else if (accept && (in_word.mode == cbcs_pkg::MODE_LOAD)) begin
      ctrl_x_r[in_word.point_index] <= in_word.point_x;
      ctrl_y_r[in_word.point_index] <= in_word.point_y;
      ctrl_c_r[in_word.point_index] <= '{blue:  in_word.point_blue,
                                         green: in_word.point_green,
                                         red:   in_word.point_red};
    end
  end

  // t = min(s, SAMPLES) / SAMPLES in Q1.16
  always_comb begin
    s_clamp = (in_word.sample_index > cbcs_pkg::S_W'(cbcs_pkg::SAMPLES))
            ? cbcs_pkg::S_W'(cbcs_pkg::SAMPLES) : in_word.sample_index;
    t_wide  = (32'(s_clamp) * 32'(cbcs_pkg::ONE_Q16)) / cbcs_pkg::SAMPLES;
    t       = t_wide[cbcs_pkg::T_W-1:0];
    t3      = (cbcs_pkg::T3_W'(t) << 1) + cbcs_pkg::T3_W'(t);
  end

  // Color segment; exactly 1/3 goes to the middle, 2/3 and 1 to the last
  always_comb begin
    priority if (t3 < cbcs_pkg::T3_W'(cbcs_pkg::ONE_Q16)) begin
      seg = cbcs_pkg::SEG_LOW;
    end else if (t3 < cbcs_pkg::T3_W'(2 * cbcs_pkg::ONE_Q16)) begin
      seg = cbcs_pkg::SEG_MID;
    end else begin
      seg = cbcs_pkg::SEG_HIGH;
    end
  end

  // Job word: coefficients from the current control points
  always_comb begin
    q_job.t  = t;
    q_job.cx = calc_coef(ctrl_x_r[0], ctrl_x_r[1], ctrl_x_r[2], ctrl_x_r[3]);
    q_job.cy = calc_coef(ctrl_y_r[0], ctrl_y_r[1], ctrl_y_r[2], ctrl_y_r[3]);
    unique case (seg)
      cbcs_pkg::SEG_MID: begin
        q_job.ca = ctrl_c_r[1];
        q_job.cb = ctrl_c_r[2];
      end
      cbcs_pkg::SEG_HIGH: begin
        q_job.ca = ctrl_c_r[2];
        q_job.cb = ctrl_c_r[3];
      end
      default: begin
        q_job.ca = ctrl_c_r[0];
        q_job.cb = ctrl_c_r[1];
      end
    endcase
  end

endmodule

### src/cbcs_fifo.sv
// Two-entry job queue between the front end and the evaluation pipeline.
// Depends on cbcs_pkg.
`timescale 1ns / 1ps

module cbcs_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbcs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cbcs_pkg::job_t pop_job
);

  cbcs_pkg::job_t                 mem_r [cbcs_pkg::Q_DEPTH];
  logic [cbcs_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [cbcs_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [cbcs_pkg::Q_CNT_W-1:0]   count_r;
  logic [cbcs_pkg::Q_CNT_W-1:0]   count_nxt;

  assign full      = (count_r == cbcs_pkg::Q_CNT_W'(cbcs_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("job queue read while empty");

  a_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && (count_r == cbcs_pkg::Q_CNT_W'(cbcs_pkg::Q_DEPTH - 1)) |=> full)
    else $error("job queue level lost an entry");

endmodule

### src/cbcs_back.sv
// Evaluation pipeline: Horner steps of the cubic with split multiplies, color blend.
// Depends on cbcs_pkg.
`timescale 1ns / 1ps

module cbcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cbcs_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbcs_pkg::out_word_t  out_word
);

  // Stage valids and advance enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic adv1, adv2, adv3, adv4, adv5;

  // Stage 1: a = c3*t + c2, colors
  logic [cbcs_pkg::T_W-1:0]          s1_t_r;
  logic signed [cbcs_pkg::A_W-1:0]   s1_a_r  [2];
  cbcs_pkg::coef_t                   s1_c1_r [2];
  cbcs_pkg::coord_t                  s1_c0_r [2];
  cbcs_pkg::rgb_t                    s1_rgb_r;
  logic signed [cbcs_pkg::A_W-1:0]   s1_a_nxt [2];
  cbcs_pkg::rgb_t                    s1_rgb_nxt;

  // Stage 2: partial products of a*t
  logic [cbcs_pkg::T_W-1:0]          s2_t_r;
  logic signed [cbcs_pkg::AHT_W-1:0] s2_hi_r [2];
  logic [cbcs_pkg::ALT_W-1:0]        s2_lo_r [2];
  cbcs_pkg::coef_t                   s2_c1_r [2];
  cbcs_pkg::coord_t                  s2_c0_r [2];
  cbcs_pkg::rgb_t                    s2_rgb_r;
  logic signed [cbcs_pkg::AHT_W-1:0] s2_hi_nxt [2];
  logic [cbcs_pkg::ALT_W-1:0]        s2_lo_nxt [2];

  // Stage 3: b = a*t + c1
  logic [cbcs_pkg::T_W-1:0]          s3_t_r;
  logic signed [cbcs_pkg::B_W-1:0]   s3_b_r  [2];
  cbcs_pkg::coord_t                  s3_c0_r [2];
  cbcs_pkg::rgb_t                    s3_rgb_r;
  logic signed [cbcs_pkg::B_W-1:0]   s3_b_nxt [2];

  // Stage 4: partial products of b*t
  logic signed [cbcs_pkg::BHT_W-1:0] s4_hi_r [2];
  logic [cbcs_pkg::BLT_W-1:0]        s4_lo_r [2];
  cbcs_pkg::coord_t                  s4_c0_r [2];
  cbcs_pkg::rgb_t                    s4_rgb_r;
  logic signed [cbcs_pkg::BHT_W-1:0] s4_hi_nxt [2];
  logic [cbcs_pkg::BLT_W-1:0]        s4_lo_nxt [2];

  // Stage 5: output register
  cbcs_pkg::out_word_t               out_word_r;
  cbcs_pkg::out_word_t               out_word_nxt;

  cbcs_pkg::axis_coef_t              job_coef [2];
  logic signed [cbcs_pkg::T_W:0]     q_t_s;
  logic signed [cbcs_pkg::T_W:0]     s1_t_s;
  logic signed [cbcs_pkg::T_W:0]     s3_t_s;
  cbcs_pkg::coord_t                  pix [2];

  // One color channel: (a*t + b*(1-t) + 1/2) in Q16, rounded half up
  function automatic logic [7:0] blend_ch(
    input logic [7:0]               a,
    input logic [7:0]               b,
    input logic [cbcs_pkg::T_W-1:0] t
  );
    logic [cbcs_pkg::T_W-1:0]     tc;
    logic [cbcs_pkg::BLEND_W-1:0] acc;
    tc  = cbcs_pkg::T_W'(cbcs_pkg::ONE_Q16) - t;
    acc = cbcs_pkg::BLEND_W'(a) * cbcs_pkg::BLEND_W'(t)
        + cbcs_pkg::BLEND_W'(b) * cbcs_pkg::BLEND_W'(tc)
        + cbcs_pkg::BLEND_W'(cbcs_pkg::ONE_Q16 / 2);
    return acc[cbcs_pkg::Q_FRAC+7:cbcs_pkg::Q_FRAC];
  endfunction

  // Round-half-up sum to integer, clamp to signed 16 bits
  function automatic cbcs_pkg::coord_t sat16(input logic signed [cbcs_pkg::N_W-1:0] n);
    logic signed [cbcs_pkg::R_W-1:0] r;
    r = n[cbcs_pkg::N_W-1:3*cbcs_pkg::Q_FRAC];
    priority if (r > cbcs_pkg::R_W'(32767)) begin
      return 16'sh7FFF;
    end else if (r < -cbcs_pkg::R_W'(32768)) begin
      return 16'sh8000;
    end else begin
      return r[cbcs_pkg::COORD_W-1:0];
    end
  endfunction

  // Stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    adv5  = !s5_v_r || !out_stall;
    adv4  = !s4_v_r || adv5;
    adv3  = !s3_v_r || adv4;
    adv2  = !s2_v_r || adv3;
    adv1  = !s1_v_r || adv2;
    q_pop = q_valid && adv1;
  end

  assign out_valid = s5_v_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= q_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
      if (adv4) s4_v_r <= s3_v_r;
      if (adv5) s5_v_r <= s4_v_r;
    end
  end

  // Stage 1 logic
  always_comb begin
    job_coef[0] = q_job.cx;
    job_coef[1] = q_job.cy;
    q_t_s       = signed'({1'b0, q_job.t});
    for (int ax = 0; ax < 2; ax++) begin
      s1_a_nxt[ax] = cbcs_pkg::A_W'(job_coef[ax].c3) * cbcs_pkg::A_W'(q_t_s)
                   + (cbcs_pkg::A_W'(job_coef[ax].c2) <<< cbcs_pkg::Q_FRAC);
    end
    s1_rgb_nxt.red   = blend_ch(q_job.ca.red,   q_job.cb.red,   q_job.t);
    s1_rgb_nxt.green = blend_ch(q_job.ca.green, q_job.cb.green, q_job.t);
    s1_rgb_nxt.blue  = blend_ch(q_job.ca.blue,  q_job.cb.blue,  q_job.t);
  end

  // Stage 2 logic: a*t as high and low partial products
  always_comb begin
    s1_t_s = signed'({1'b0, s1_t_r});
    for (int ax = 0; ax < 2; ax++) begin
      s2_hi_nxt[ax] = cbcs_pkg::AHT_W'(signed'(s1_a_r[ax][cbcs_pkg::A_W-1:cbcs_pkg::A_LO_W]))
                    * cbcs_pkg::AHT_W'(s1_t_s);
      s2_lo_nxt[ax] = cbcs_pkg::ALT_W'(s1_a_r[ax][cbcs_pkg::A_LO_W-1:0])
                    * cbcs_pkg::ALT_W'(s1_t_r);
    end
  end

  // Stage 3 logic: recombine and add c1
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      s3_b_nxt[ax] = (cbcs_pkg::B_W'(s2_hi_r[ax]) <<< cbcs_pkg::A_LO_W)
                   + cbcs_pkg::B_W'(signed'({1'b0, s2_lo_r[ax]}))
                   + (cbcs_pkg::B_W'(s2_c1_r[ax]) <<< (2 * cbcs_pkg::Q_FRAC));
    end
  end

  // Stage 4 logic: b*t as high and low partial products
  always_comb begin
    s3_t_s = signed'({1'b0, s3_t_r});
    for (int ax = 0; ax < 2; ax++) begin
      s4_hi_nxt[ax] = cbcs_pkg::BHT_W'(signed'(s3_b_r[ax][cbcs_pkg::B_W-1:cbcs_pkg::B_LO_W]))
                    * cbcs_pkg::BHT_W'(s3_t_s);
      s4_lo_nxt[ax] = cbcs_pkg::BLT_W'(s3_b_r[ax][cbcs_pkg::B_LO_W-1:0])
                    * cbcs_pkg::BLT_W'(s3_t_r);
    end
  end

  // Stage 5 logic: add c0 and one half, round, clamp
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      pix[ax] = sat16((cbcs_pkg::N_W'(s4_hi_r[ax]) <<< cbcs_pkg::B_LO_W)
                    + cbcs_pkg::N_W'(signed'({1'b0, s4_lo_r[ax]}))
                    + (cbcs_pkg::N_W'(s4_c0_r[ax]) <<< (3 * cbcs_pkg::Q_FRAC))
                    + (cbcs_pkg::N_W'(1) <<< (3 * cbcs_pkg::Q_FRAC - 1)));
    end
    out_word_nxt.pixel_x     = pix[0];
    out_word_nxt.pixel_y     = pix[1];
    out_word_nxt.pixel_red   = s4_rgb_r.red;
    out_word_nxt.pixel_green = s4_rgb_r.green;
    out_word_nxt.pixel_blue  = s4_rgb_r.blue;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_t_r   <= q_job.t;
      s1_rgb_r <= s1_rgb_nxt;
      for (int ax = 0; ax < 2; ax++) begin
        s1_a_r[ax]  <= s1_a_nxt[ax];
        s1_c1_r[ax] <= job_coef[ax].c1;
        s1_c0_r[ax] <= job_coef[ax].c0;
      end
    end
    if (adv2) begin
      s2_t_r   <= s1_t_r;
      s2_rgb_r <= s1_rgb_r;
      for (int ax = 0; ax < 2; ax++) begin
        s2_hi_r[ax] <= s2_hi_nxt[ax];
        s2_lo_r[ax] <= s2_lo_nxt[ax];
        s2_c1_r[ax] <= s1_c1_r[ax];
        s2_c0_r[ax] <= s1_c0_r[ax];
      end
    end
    if (adv3) begin
      s3_t_r   <= s2_t_r;
      s3_rgb_r <= s2_rgb_r;
      for (int ax = 0; ax < 2; ax++) begin
        s3_b_r[ax]  <= s3_b_nxt[ax];
        s3_c0_r[ax] <= s2_c0_r[ax];
      end
    end
    if (adv4) begin
      s4_rgb_r <= s3_rgb_r;
      for (int ax = 0; ax < 2; ax++) begin
        s4_hi_r[ax] <= s4_hi_nxt[ax];
        s4_lo_r[ax] <= s4_lo_nxt[ax];
        s4_c0_r[ax] <= s3_c0_r[ax];
      end
    end
    if (adv5) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("job popped from empty queue");

  a_empty_head_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !s1_v_r |-> q_pop) else $error("pipeline head idle with a job waiting");

  a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && s5_v_r && out_stall |=> s4_v_r)
    else $error("stage 4 word lost while output stalled");

endmodule

### src/cubic_bezier_color_sampler.sv
// Top level of the cubic Bezier color sampler: front end, job queue, evaluation pipeline.
// Depends on cbcs_pkg, cbcs_front, cbcs_fifo and cbcs_back.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   cbcs_pkg::in_word_t (load or sample)
//   out      output     out_valid / out_stall cbcs_pkg::out_word_t (one per sample)
//
// One word per clock in steady flow; a load word is absorbed in its accept cycle.
// A sample word passes from the job queue through the five pipeline stages set by
// the split multiplies of Horner's rule; its result is registered in the last stage.
// Synchronous active-low reset empties the queue and pipeline and zeroes the control points.
// out_stall backs up the pipeline into the two-entry queue; in_stall rises when it is full.
`timescale 1ns / 1ps

module cubic_bezier_color_sampler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cbcs_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbcs_pkg::out_word_t  out_word
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  cbcs_pkg::job_t q_in_job;
  cbcs_pkg::job_t q_out_job;

  cbcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  cbcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (q_out_job)
  );

  cbcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
